// ===== src/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Shared constants for the front, queue and back modules.
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int DEF_COORD_BITS = 10;
    localparam int QUEUE_DEPTH    = 2;
    localparam int PIX_PER_POINT  = 8;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

endpackage

// ===== src/mcr_queue.sv =====
// ----------------------------------------------------------------------------
// Point queue
// Small register queue that carries point jobs from the front to the back.
// ----------------------------------------------------------------------------
module mcr_queue #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds its depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

// ===== src/mcr_front.sv =====
// ----------------------------------------------------------------------------
// Rasterizer front end
// Accepts start and step words, walks the octant and queues each point.
// ----------------------------------------------------------------------------
module mcr_front #(
    parameter int COORD_BITS = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      mode,
    input  logic [COORD_BITS-1:0]     center_x,
    input  logic [COORD_BITS-1:0]     center_y,
    input  logic [COORD_BITS-1:0]     radius,
    output logic                      push,
    output logic [4*COORD_BITS:0]     push_data,
    input  logic                      queue_full
);
    import mcr_pkg::*;

    localparam int DEC_W = COORD_BITS + 3;

    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cx_next;
    logic [COORD_BITS-1:0] cy_reg;
    logic [COORD_BITS-1:0] cy_next;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] x_next;
    logic [COORD_BITS-1:0] y_reg;
    logic [COORD_BITS-1:0] y_next;
    logic [DEC_W-1:0]      dec_reg;
    logic [DEC_W-1:0]      dec_next;
    logic                  active_reg;
    logic                  active_next;
    logic                  accept;
    logic                  final_point;
    logic [DEC_W-1:0]      x2;
    logic [DEC_W-1:0]      y2;

    assign in_stall    = queue_full;
    assign accept      = in_valid && !in_stall;
    assign final_point = !(y_reg > x_reg);
    assign push        = accept && (mode == MODE_STEP) && active_reg;
    assign push_data   = {cx_reg, cy_reg, x_reg, y_reg, final_point};
    assign x2          = {2'b00, x_reg, 1'b0};
    assign y2          = {2'b00, y_reg, 1'b0};

    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        dec_next    = dec_reg;
        active_next = active_reg;
        if (accept && (mode == MODE_START))
        begin
            cx_next     = center_x;
            cy_next     = center_y;
            x_next      = '0;
            y_next      = radius;
            dec_next    = DEC_W'(1) - {3'b000, radius};
            active_next = 1'b1;
        end
        else if (push)
        begin
            if (final_point)
            begin
                active_next = 1'b0;
            end
            else
            begin
                if (dec_reg[DEC_W-1])
                begin
                    dec_next = dec_reg + x2 + DEC_W'(3);
                end
                else
                begin
                    dec_next = dec_reg + x2 - y2 + DEC_W'(5);
                    y_next   = y_reg - 1'b1;
                end
                x_next = x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            dec_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            dec_reg    <= dec_next;
            active_reg <= active_next;
        end
    end

    a_final_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (push && final_point) |=> !active_reg)
        else $error("walk stayed active after its final point");

    a_step_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !final_point) |=> (x_reg == $past(x_reg) + 1'b1))
        else $error("x did not advance after a step");

endmodule

// ===== src/mcr_back.sv =====
// ----------------------------------------------------------------------------
// Rasterizer back end
// Each queued point yields eight symmetric pixels, one per unstalled cycle.
// ----------------------------------------------------------------------------
module mcr_back #(
    parameter int COORD_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_avail,
    input  logic [4*COORD_BITS:0]        job_data,
    output logic                         job_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS+1:0] pixel_x,
    output logic signed [COORD_BITS+1:0] pixel_y,
    output logic                         last_of_point,
    output logic                         circle_done
);
    import mcr_pkg::*;

    localparam int IDX_W = $clog2(PIX_PER_POINT);
    localparam int PIX_W = COORD_BITS + 2;

    logic                  job_valid_reg;
    logic                  job_valid_next;
    logic [4*COORD_BITS:0] job_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PIX_W-1:0]      px_reg;
    logic [PIX_W-1:0]      py_reg;
    logic                  last_reg;
    logic                  done_reg;
    logic                  advance;
    logic                  idx_last;
    logic [COORD_BITS-1:0] h;
    logic [COORD_BITS-1:0] k;
    logic [COORD_BITS-1:0] jx;
    logic [COORD_BITS-1:0] jy;
    logic                  jfinal;
    logic [COORD_BITS-1:0] a;
    logic [COORD_BITS-1:0] b;
    logic [PIX_W-1:0]      px_calc;
    logic [PIX_W-1:0]      py_calc;

    assign {h, k, jx, jy, jfinal} = job_reg;
    assign advance  = job_valid_reg && (!out_valid_reg || !out_stall);
    assign idx_last = (idx_reg == IDX_W'(PIX_PER_POINT - 1));
    assign job_pop  = job_avail && (!job_valid_reg || (advance && idx_last));

    assign a       = idx_reg[IDX_W-1] ? jy : jx;
    assign b       = idx_reg[IDX_W-1] ? jx : jy;
    assign px_calc = idx_reg[0] ? ({2'b00, h} - {2'b00, a}) : ({2'b00, h} + {2'b00, a});
    assign py_calc = idx_reg[1] ? ({2'b00, k} - {2'b00, b}) : ({2'b00, k} + {2'b00, b});

    always_comb
    begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        if (advance)
        begin
            idx_next = idx_last ? '0 : idx_reg + 1'b1;
            if (idx_last)
            begin
                job_valid_next = 1'b0;
            end
        end
        if (job_pop)
        begin
            job_valid_next = 1'b1;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job_data;
        end
        if (advance)
        begin
            px_reg   <= px_calc;
            py_reg   <= py_calc;
            last_reg <= idx_last;
            done_reg <= idx_last && jfinal;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_x       = $signed(px_reg);
    assign pixel_y       = $signed(py_reg);
    assign last_of_point = last_reg;
    assign circle_done   = done_reg;

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> last_reg)
        else $error("circle done flagged on a pixel that does not end a point");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !job_valid_reg |-> (idx_reg == '0))
        else $error("pixel index not at zero with no point loaded");

endmodule

// ===== src/midpoint_circle_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer
// Start words load a circle; step words emit the eight symmetric pixels of
// the current octant point and advance the walk.
// ----------------------------------------------------------------------------
// The first pixel of a step word passes the point queue, the back end's job
// register and its pixel output register; the other seven follow at one pixel
// per cycle while out_stall is low, over the single pixel output port.
// Words are taken while the queue has room; start and idle step words produce
// no pixel. Reset clears the walk state, point queue and output valid at once.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS = mcr_pkg::DEF_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic [COORD_BITS-1:0]        center_x,
    input  logic [COORD_BITS-1:0]        center_y,
    input  logic [COORD_BITS-1:0]        radius,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS+1:0] pixel_x,
    output logic signed [COORD_BITS+1:0] pixel_y,
    output logic                         last_of_point,
    output logic                         circle_done
);
    import mcr_pkg::*;

    localparam int JOB_W = 4 * COORD_BITS + 1;

    logic             push;
    logic [JOB_W-1:0] push_data;
    logic             queue_full;
    logic             pop;
    logic             queue_not_empty;
    logic [JOB_W-1:0] pop_data;

    mcr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    mcr_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_data  (pop_data)
    );

    mcr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_avail     (queue_not_empty),
        .job_data      (pop_data),
        .job_pop       (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .last_of_point (last_of_point),
        .circle_done   (circle_done)
    );

endmodule

// ===== bench/midpoint_circle_rasterizer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer testbench
// Feeds start and step words through a randomly idling driver, follows the
// octant walk in a local model and checks every pixel word that the block
// returns, while the pixel receiver stalls at random and once for a long spell.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_test;
    import mcr_pkg::*;

    localparam int CB         = DEF_COORD_BITS;
    localparam int PIX_BITS   = CB + 2;
    localparam int QUIET_MAX  = 2000;
    localparam int LONG_HOLD  = 400;
    localparam int RAND_WORDS = 305;

    typedef struct {
        logic          mode;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [CB-1:0] r;
        bit            wait_drain;
    } word_t;

    typedef struct {
        logic signed [PIX_BITS-1:0] px;
        logic signed [PIX_BITS-1:0] py;
        logic                       last;
        logic                       done;
    } pixel_t;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic                       mode      = MODE_START;
    logic [CB-1:0]              center_x  = '0;
    logic [CB-1:0]              center_y  = '0;
    logic [CB-1:0]              radius    = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [PIX_BITS-1:0] pixel_x;
    logic signed [PIX_BITS-1:0] pixel_y;
    logic                       last_of_point;
    logic                       circle_done;

    word_t  pending_words[$];
    pixel_t pixel_queue[$];

    logic [CB-1:0]     walk_cx   = '0;
    logic [CB-1:0]     walk_cy   = '0;
    logic [CB-1:0]     walk_x    = '0;
    logic [CB-1:0]     walk_y    = '0;
    logic signed [12:0] walk_err = '0;
    logic              walking   = 1'b0;

    logic settled   = 1'b1;
    logic long_hold = 1'b0;
    int   send_gap  = 0;
    bit   send_burst = 1'b0;
    int   recv_wait = 0;
    bit   recv_burst = 1'b0;
    int   quiet     = 0;

    int words_taken   = 0;
    int starts_taken  = 0;
    int pixels_seen   = 0;
    int circles_drawn = 0;
    int mismatches    = 0;

    midpoint_circle_rasterizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .center_x      (center_x),
        .center_y      (center_y),
        .radius        (radius),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .last_of_point (last_of_point),
        .circle_done   (circle_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic plan_word(logic m, int cx, int cy, int r, bit drain);
        word_t w;
        w.mode       = m;
        w.cx         = cx[CB-1:0];
        w.cy         = cy[CB-1:0];
        w.r          = r[CB-1:0];
        w.wait_drain = drain;
        pending_words.push_back(w);
    endtask

    task automatic plan_steps(int n);
        for (int i = 0; i < n; i++)
        begin
            plan_word(MODE_STEP, $urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), 1'b0);
        end
    endtask

    function automatic void push_pixel(int px, int py, logic last, logic done);
        pixel_t p;
        p.px   = px[PIX_BITS-1:0];
        p.py   = py[PIX_BITS-1:0];
        p.last = last;
        p.done = done;
        pixel_queue.push_back(p);
    endfunction

    always @(posedge clk)
    begin : word_driver
        word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_words.size() != 0 &&
                     (!pending_words[0].wait_drain || (!in_valid && settled)))
            begin
                w = pending_words.pop_front();
                mode     <= w.mode;
                center_x <= w.cx;
                center_y <= w.cy;
                radius   <= w.r;
                in_valid <= 1'b1;
                if ($urandom_range(0, 15) == 0)
                    send_burst = !send_burst;
                send_gap <= send_burst ? 0 : $urandom_range(0, 17);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : pixel_receiver
        int w;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if ($urandom_range(0, 15) == 0)
                    recv_burst = !recv_burst;
                w = recv_burst ? 0 : $urandom_range(0, 17);
            end
            else
            begin
                w = (recv_wait > 0) ? recv_wait - 1 : 0;
            end
            recv_wait <= w;
            out_stall <= long_hold || (w != 0);
        end
    end

    always @(posedge clk)
    begin : scoreboard
        pixel_t seen;
        pixel_t want;
        int     h;
        int     k;
        int     x;
        int     y;
        logic   final_pt;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen.px   = pixel_x;
                seen.py   = pixel_y;
                seen.last = last_of_point;
                seen.done = circle_done;
                pixels_seen++;
                if (circle_done)
                    circles_drawn++;
                if (pixel_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected pixel x=%0d y=%0d last=%b done=%b",
                                 $realtime, seen.px, seen.py, seen.last, seen.done);
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    if (seen.px !== want.px || seen.py !== want.py ||
                        seen.last !== want.last || seen.done !== want.done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: pixel %0d exp %0d,%0d,%b,%b got %0d,%0d,%b,%b",
                                     $realtime, pixels_seen, want.px, want.py, want.last,
                                     want.done, seen.px, seen.py, seen.last, seen.done);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                words_taken++;
                if (mode == MODE_START)
                begin
                    starts_taken++;
                    walk_cx  = center_x;
                    walk_cy  = center_y;
                    walk_x   = '0;
                    walk_y   = radius;
                    walk_err = 13'(1 - int'(radius));
                    walking  = 1'b1;
                end
                else if (walking)
                begin
                    h = int'(walk_cx);
                    k = int'(walk_cy);
                    x = int'(walk_x);
                    y = int'(walk_y);
                    final_pt = !(y > x);
                    push_pixel(h + x, k + y, 1'b0, 1'b0);
                    push_pixel(h - x, k + y, 1'b0, 1'b0);
                    push_pixel(h + x, k - y, 1'b0, 1'b0);
                    push_pixel(h - x, k - y, 1'b0, 1'b0);
                    push_pixel(h + y, k + x, 1'b0, 1'b0);
                    push_pixel(h - y, k + x, 1'b0, 1'b0);
                    push_pixel(h + y, k - x, 1'b0, 1'b0);
                    push_pixel(h - y, k - x, 1'b1, final_pt);
                    if (final_pt)
                    begin
                        walking = 1'b0;
                    end
                    else
                    begin
                        if (walk_err < 0)
                        begin
                            walk_err = 13'(int'(walk_err) + 2 * x + 3);
                        end
                        else
                        begin
                            walk_err = 13'(int'(walk_err) + 2 * (x - y) + 5);
                            walk_y   = walk_y - 1'b1;
                        end
                        walk_x = walk_x + 1'b1;
                    end
                end
            end
            settled <= (pixel_queue.size() == 0);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet <= 0;
            end
            else if (quiet >= QUIET_MAX)
            begin
                $display("%0t: no word moved for %0d cycles", $realtime, QUIET_MAX);
                $display("RESULT: ERROR");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    initial
    begin : receiver_hold
        wait (words_taken >= 60);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin : stimulus
        int pick;
        int r;
        int n;
        int tail;
        int gx;
        int gy;
        int gd;

        plan_word(MODE_STEP, 1023, 1023, 1023, 1'b0);
        plan_word(MODE_START, 0, 0, 0, 1'b0);
        plan_steps(2);
        plan_word(MODE_START, 1023, 1023, 0, 1'b0);
        plan_steps(1);
        plan_word(MODE_START, 0, 0, 1023, 1'b0);
        plan_steps(2);
        plan_word(MODE_START, 1023, 1023, 1023, 1'b0);
        plan_steps(2);
        plan_word(MODE_START, 512, 512, 1, 1'b1);
        plan_steps(2);
        plan_word(MODE_START, 0, 1023, 2, 1'b0);
        plan_steps(3);
        plan_word(MODE_START, 1023, 0, 682, 1'b0);
        plan_steps(2);
        plan_word(MODE_START, 341, 682, 5, 1'b0);
        plan_steps(5);

        while (pending_words.size() < RAND_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                tail = $urandom_range(0, 99);
                if (tail < 85)
                    r = $urandom_range(0, 12);
                else if (tail < 95)
                    r = $urandom_range(13, 40);
                else
                    r = $urandom_range(0, 1023);
                plan_word(MODE_START, $urandom_range(0, 1023), $urandom_range(0, 1023), r,
                          $urandom_range(0, 29) == 0);
                if (r <= 40)
                begin
                    gx = 0;
                    gy = r;
                    gd = 1 - r;
                    n  = 1;
                    while (gy > gx)
                    begin
                        if (gd < 0)
                        begin
                            gd = gd + 2 * gx + 3;
                        end
                        else
                        begin
                            gd = gd + 2 * (gx - gy) + 5;
                            gy = gy - 1;
                        end
                        gx = gx + 1;
                        n  = n + 1;
                    end
                    tail = $urandom_range(0, 9);
                    if (tail == 0)
                        n = n + 1;
                    else if (tail == 1)
                        n = $urandom_range(0, n - 1);
                end
                else
                begin
                    n = $urandom_range(1, 6);
                end
                plan_steps(n);
            end
            else if (pick < 90)
            begin
                plan_steps($urandom_range(1, 3));
            end
            else
            begin
                plan_word(MODE_START, $urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), 1'b0);
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (!(pending_words.size() == 0 && !in_valid && pixel_queue.size() == 0));
        repeat (20) @(negedge clk);

        $display("Sent %0d words, %0d of them circle starts; checked %0d pixels.",
                 words_taken, starts_taken, pixels_seen);
        $display("Circles drawn to completion: %0d; mismatching pixels: %0d.",
                 circles_drawn, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
